>>> rtl/core/utf16le_to_utf8_transcoder_assert.svh
// Assertion macros for the UTF-16LE to UTF-8 transcoder.
// Needs aclk and aresetn in the scope of every use.
`ifndef UTF16LE_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define U16U8_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/u16u8_pkg.sv
// Shared types, constants and UTF-8 encoding helpers for the transcoder.
// No dependencies.
package u16u8_pkg;

    localparam int CP_W        = 21;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam logic [5:0]      HI_SUR_TAG = 6'b110110;
    localparam logic [5:0]      LO_SUR_TAG = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE  = 21'h10000;

    // one encode job: a code point plus the flags of its final byte
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            run_end;
        logic            text_end;
        logic            odd_err;
    } job_t;

    // number of UTF-8 bytes minus one
    function automatic logic [1:0] utf8_last_idx(input logic [CP_W-1:0] cp);
        logic [1:0] n;
        if (cp[CP_W-1:7] == '0) begin
            n = 2'd0;
        end else if (cp[CP_W-1:11] == '0) begin
            n = 2'd1;
        end else if (cp[CP_W-1:16] == '0) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0] last_idx,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (last_idx)
            2'd0: b = cp[7:0];
            2'd1: begin
                case (idx)
                    2'd0:    b = {3'b110, cp[10:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            2'd2: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/u16u8_queue.sv
// Short job queue between the front and back ends of the transcoder.
// Depends on u16u8_pkg.
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/u16u8_front.sv
// Front end: pairs bytes into UTF-16 units, tracks a held high surrogate and
// emits zero, one or two encode jobs per input word. Depends on u16u8_pkg.
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       q_push,
    output job_t       q_data,
    input  logic       q_full
);

    logic       phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [9:0] pend_reg, pend_next;
    logic       pend_valid_reg, pend_valid_next;
    job_t       second_reg, second_next;
    logic       second_valid_reg, second_valid_next;

    logic            acc;
    logic [15:0]     unit;
    logic            is_hi, is_lo;
    logic [CP_W-1:0] rel_cp, new_rel_cp, pair_cp, unit_cp;
    logic [1:0]      n_jobs;
    job_t            j0, j1;

    assign in_ready = !second_valid_reg && !q_full;
    assign acc      = in_valid && in_ready;

    assign unit       = {in_byte, held_reg};
    assign is_hi      = (unit[15:10] == HI_SUR_TAG);
    assign is_lo      = (unit[15:10] == LO_SUR_TAG);
    assign rel_cp     = {5'b0, HI_SUR_TAG, pend_reg};
    assign new_rel_cp = {5'b0, HI_SUR_TAG, unit[9:0]};
    assign pair_cp    = SUPP_BASE + {1'b0, pend_reg, unit[9:0]};
    assign unit_cp    = {5'b0, unit};

    always_comb begin
        phase_next      = phase_reg;
        held_next       = held_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        n_jobs          = 2'd0;
        j0              = '0;
        j1              = '0;
        if (acc) begin
            if (!phase_reg) begin
                if (in_last) begin
                    // odd byte count: single error word, drop everything held
                    n_jobs          = 2'd1;
                    j0              = '{cp: '0, run_end: 1'b1, text_end: 1'b1, odd_err: 1'b1};
                    held_next       = '0;
                    pend_next       = '0;
                    pend_valid_next = 1'b0;
                end else begin
                    held_next  = in_byte;
                    phase_next = 1'b1;
                end
            end else begin
                phase_next = 1'b0;
                held_next  = '0;
                if (pend_valid_reg && is_lo) begin
                    n_jobs          = 2'd1;
                    j0              = '{cp: pair_cp, run_end: 1'b1, text_end: in_last,
                                        odd_err: 1'b0};
                    pend_next       = '0;
                    pend_valid_next = 1'b0;
                end else if (pend_valid_reg) begin
                    j0 = '{cp: rel_cp, run_end: 1'b0, text_end: 1'b0, odd_err: 1'b0};
                    if (is_hi) begin
                        if (in_last) begin
                            n_jobs          = 2'd2;
                            j1              = '{cp: new_rel_cp, run_end: 1'b1,
                                                text_end: 1'b1, odd_err: 1'b0};
                            pend_next       = '0;
                            pend_valid_next = 1'b0;
                        end else begin
                            n_jobs          = 2'd1;
                            j0.run_end      = 1'b1;
                            pend_next       = unit[9:0];
                            pend_valid_next = 1'b1;
                        end
                    end else begin
                        n_jobs          = 2'd2;
                        j1              = '{cp: unit_cp, run_end: 1'b1, text_end: in_last,
                                            odd_err: 1'b0};
                        pend_next       = '0;
                        pend_valid_next = 1'b0;
                    end
                end else if (is_hi) begin
                    if (in_last) begin
                        n_jobs = 2'd1;
                        j0     = '{cp: new_rel_cp, run_end: 1'b1, text_end: 1'b1,
                                   odd_err: 1'b0};
                    end else begin
                        pend_next       = unit[9:0];
                        pend_valid_next = 1'b1;
                    end
                end else begin
                    n_jobs = 2'd1;
                    j0     = '{cp: unit_cp, run_end: 1'b1, text_end: in_last, odd_err: 1'b0};
                end
            end
        end
    end

    // a word that yields two jobs parks the second one here until the queue takes it
    always_comb begin
        second_next       = second_reg;
        second_valid_next = second_valid_reg;
        if (second_valid_reg) begin
            q_push = !q_full;
            q_data = second_reg;
            if (!q_full) begin
                second_valid_next = 1'b0;
            end
        end else begin
            q_push = (n_jobs != 2'd0);
            q_data = j0;
            if (n_jobs == 2'd2) begin
                second_next       = j1;
                second_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= 1'b0;
            held_reg         <= '0;
            pend_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            second_valid_reg <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            held_reg         <= held_next;
            pend_reg         <= pend_next;
            pend_valid_reg   <= pend_valid_next;
            second_valid_reg <= second_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        second_reg <= second_next;
    end

endmodule

>>> rtl/core/u16u8_back.sv
// Back end: takes encode jobs from the queue and serializes them into UTF-8
// bytes, one per cycle while out_ready is high, through an output register. Depends on u16u8_pkg.
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       q_data,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_run_end,
    output logic       out_text_end,
    output logic       out_odd_err
);

    job_t       job_reg;
    logic       job_valid_reg, job_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] obyte_reg;
    logic       orun_reg, otext_reg, oerr_reg;

    logic [1:0] last_idx;
    logic       last_byte;
    logic       out_load;

    assign last_idx  = utf8_last_idx(job_reg.cp);
    assign last_byte = (idx_reg == last_idx);
    assign out_load  = job_valid_reg && (!ovalid_reg || out_ready);
    assign q_pop     = !q_empty && (!job_valid_reg || (out_load && last_byte));

    always_comb begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        ovalid_next    = ovalid_reg;
        if (out_ready) begin
            ovalid_next = 1'b0;
        end
        if (out_load) begin
            ovalid_next = 1'b1;
            if (last_byte) begin
                job_valid_next = 1'b0;
                idx_next       = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (q_pop) begin
            job_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            ovalid_reg    <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_data;
        end
        if (out_load) begin
            obyte_reg <= utf8_byte(job_reg.cp, last_idx, idx_reg);
            orun_reg  <= last_byte && job_reg.run_end;
            otext_reg <= last_byte && job_reg.text_end;
            oerr_reg  <= last_byte && job_reg.odd_err;
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_byte     = obyte_reg;
    assign out_run_end  = orun_reg;
    assign out_text_end = otext_reg;
    assign out_odd_err  = oerr_reg;

endmodule

>>> rtl/core/utf16le_to_utf8_transcoder.sv
// UTF-16LE to UTF-8 transcoder, top level.
// Uses u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back and the assert header.
// Input stream (s_*): one byte of UTF-16LE text per word, low byte of each code
//   unit first; s_tlast marks the final byte of a text.
// Output stream (m_*): one UTF-8 byte per word. m_tlast marks the last byte of
//   a text, m_tuser[0] the last byte caused by an input word, and m_tuser[1]
//   an error word (data zero) closing a text of odd byte count; the consumer
//   discards that text.
// A high surrogate is held until the next unit: a low surrogate completes a
//   4-byte sequence, anything else (or end of text) releases it as 3 bytes.
// Timing: the front end classifies each unit and writes encode jobs into a
//   four-entry queue; the back end drains one job at a time, one byte per
//   cycle while m_tready is high. A completing input word's first byte passes
//   through the queue, the job register and the output register. Input takes
//   one word per cycle while the queue has room, except for a stall after a
//   word that yields two jobs, until its second job is queued. Sustained rate
//   is set by the output serializer at one UTF-8 byte per cycle, so input
//   slows on common text (three bytes per unit). When m_tready is low the
//   output register holds, the queue fills and then s_tready drops.
//   Synchronous reset clears all held bytes, surrogates and queued jobs.
module utf16le_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] run_end, [1] odd_length_error
    output logic       m_tlast    // text_end
);

    logic q_push, q_full, q_pop, q_empty;
    job_t q_wdata, q_rdata;

    u16u8_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    u16u8_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    u16u8_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_data       (q_rdata),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_run_end  (m_tuser[0]),
        .out_text_end (m_tlast),
        .out_odd_err  (m_tuser[1])
    );

`include "utf16le_to_utf8_transcoder_assert.svh"

    // an error word always closes both its run and its text
`U16U8_ASSERT_NOW(a_err_closes, m_tvalid && m_tuser[1], m_tlast && m_tuser[0], "bad error word")
    // the end of a text is also the end of the run of its last input word
`U16U8_ASSERT_NOW(a_text_end_run, m_tvalid && m_tlast, m_tuser[0], "text end without run end")
    // the front end never writes a full queue
`U16U8_ASSERT_NOW(a_no_overflow, q_push, !q_full, "job queue overflow")
    // the back end never reads an empty queue
`U16U8_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "job queue underflow")

endmodule
